// ===== hw/rtl/rsb_pkg.sv =====
`default_nettype none

package rsb_pkg;

    localparam int CMD_W      = 4;
    localparam int INDEX_W    = 12;
    localparam int VALUE_W    = 8;
    localparam int MASK_LEN_W = 13;

    localparam logic [MASK_LEN_W-1:0] MASK_LEN_RESET = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_SET_BIT    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_READ_BIT   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_OR_BIT     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_AND_BIT    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 4'd4;
    localparam logic [CMD_W-1:0] CMD_FILL_ONES  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_OR_BYTE    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_AND_BYTE   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_NONE_QUERY = 4'd8;

    // How the controller handles an incoming item
    localparam logic [1:0] KIND_RMW  = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic read_bit;
        logic is_none;
        logic index_error;
    } rsp_t;

    typedef struct packed {
        logic cap;          // latch item, read its byte
        logic rmw_wr;       // write back modified byte
        logic sweep_start;
        logic sweep_wr;     // write 0xFF at sweep counter
        logic none_start;
        logic none_step;
        logic load_out;
        logic save_res;
        logic use_saved;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       sweep_last;
        logic       none_done;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsb_ram.sv =====
`default_nettype none

module rsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rsb_ctrl.sv =====
`default_nettype none

module rsb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    input  wire rsb_pkg::sts_t sts,
    output rsb_pkg::ctrl_t     cmd
);

    import rsb_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MODIFY = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_NONE   = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.cap = 1'b1;
                if (req_valid)
                begin
                    unique case (sts.kind)
                        KIND_FILL:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_FILL;
                        end
                        KIND_NONE:
                        begin
                            cmd.none_start = 1'b1;
                            state_next     = ST_NONE;
                        end
                        default:
                        begin
                            state_next = ST_MODIFY;
                        end
                    endcase
                end
            end
            ST_MODIFY:
            begin
                cmd.rmw_wr = 1'b1;
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.save_res = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_FILL:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.save_res = 1'b1;
                        state_next   = ST_RESP;
                    end
                end
            end
            ST_NONE:
            begin
                cmd.none_step = 1'b1;
                if (sts.none_done)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.save_res = 1'b1;
                        state_next   = ST_RESP;
                    end
                end
            end
            ST_RESP:
            begin
                cmd.use_saved = 1'b1;
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rsb_datapath.sv =====
`default_nettype none

module rsb_datapath #(
    parameter int MAX_BITS = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rsb_pkg::MASK_LEN_W-1:0]      cfg_wr_data,
    input  wire rsb_pkg::req_t                       req,
    input  wire rsb_pkg::ctrl_t                      cmd,
    output rsb_pkg::sts_t                            sts,
    output rsb_pkg::rsp_t                            rsp
);

    import rsb_pkg::*;

    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW = AW + 1;
    localparam int UW = ($clog2(MAX_BITS + 1) > MASK_LEN_W) ? $clog2(MAX_BITS + 1)
                                                            : MASK_LEN_W;

    req_t                  item_reg;
    logic [MASK_LEN_W-1:0] mlen_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  chk_valid_reg;
    logic                  chk_valid_next;
    logic                  chk_last_reg;
    logic                  chk_last_next;
    logic                  any_reg;
    logic                  any_next;
    rsp_t                  res_reg;
    rsp_t                  rsp_reg;

    logic [UW-1:0]         used;
    logic [UW:0]           used_sum;
    logic [CW-1:0]         nbytes;
    logic [7:0]            last_mask;
    logic                  issue;

    logic [1:0]            req_kind;
    logic                  sweep_last;
    logic                  none_done;

    logic [AW-1:0]         req_addr;
    logic [AW-1:0]         item_addr;
    logic                  item_in_store;
    logic                  bit_err;
    logic [7:0]            bit_mask;
    logic [7:0]            old_byte;
    logic [7:0]            new_byte;
    logic                  wr_ok;
    rsp_t                  fin_res;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [7:0]            ram_wdata;
    logic [AW-1:0]         ram_raddr;

    // Length in use, clamped to the store
    assign used = (UW'(mlen_reg) > UW'(MAX_BITS)) ? UW'(MAX_BITS) : UW'(mlen_reg);
    assign used_sum = (UW+1)'(used) + (UW+1)'(7);
    assign nbytes   = CW'(used_sum >> 3);
    assign last_mask = (used[2:0] == 3'd0) ? 8'hFF : 8'((9'd1 << used[2:0]) - 9'd1);

    assign req_addr      = AW'(req.index[INDEX_W-1:3]);
    assign item_addr     = AW'(item_reg.index[INDEX_W-1:3]);
    assign item_in_store = (32'(item_reg.index[INDEX_W-1:3]) < STORE_BYTES);
    assign bit_err       = (UW'(item_reg.index) >= used) || !item_in_store;
    assign bit_mask      = 8'd1 << item_reg.index[2:0];

    always_comb
    begin
        unique case (req.cmd)
            CMD_FILL_ONES:  req_kind = KIND_FILL;
            CMD_NONE_QUERY: req_kind = KIND_NONE;
            default:        req_kind = KIND_RMW;
        endcase
    end

    always_comb
    begin
        new_byte = old_byte;
        wr_ok    = 1'b0;
        fin_res  = '0;
        unique case (item_reg.cmd)
            CMD_SET_BIT:
            begin
                fin_res.index_error = bit_err;
                wr_ok               = !bit_err;
                new_byte = (item_reg.value != '0) ? (old_byte | bit_mask)
                                                  : (old_byte & ~bit_mask);
            end
            CMD_READ_BIT:
            begin
                fin_res.index_error = bit_err;
                fin_res.read_bit    = !bit_err && ((old_byte & bit_mask) != 8'd0);
            end
            CMD_OR_BIT:
            begin
                fin_res.index_error = bit_err;
                wr_ok               = !bit_err && (item_reg.value == VALUE_W'(1));
                new_byte            = old_byte | bit_mask;
            end
            CMD_AND_BIT:
            begin
                fin_res.index_error = bit_err;
                wr_ok               = !bit_err && (item_reg.value == '0);
                new_byte            = old_byte & ~bit_mask;
            end
            CMD_WRITE_BYTE:
            begin
                wr_ok    = item_in_store;
                new_byte = item_reg.value;
            end
            CMD_OR_BYTE:
            begin
                wr_ok    = item_in_store;
                new_byte = old_byte | item_reg.value;
            end
            CMD_AND_BYTE:
            begin
                wr_ok    = item_in_store;
                new_byte = old_byte & item_reg.value;
            end
            CMD_NONE_QUERY:
            begin
                fin_res.is_none = !any_reg;
            end
            default:
            begin
                wr_ok = 1'b0;
            end
        endcase
    end

    // Sweep and none-walk share one counter
    assign issue = (cnt_reg < nbytes);

    always_comb
    begin
        if (cmd.sweep_start || cmd.none_start)
        begin
            cnt_next = '0;
        end
        else if (cmd.sweep_wr || (cmd.none_step && issue))
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    assign chk_valid_next = cmd.none_step && issue;
    assign chk_last_next  = issue && (cnt_reg == nbytes - CW'(1));

    always_comb
    begin
        if (cmd.none_start)
        begin
            any_next = 1'b0;
        end
        else if (chk_valid_reg)
        begin
            any_next = any_reg | (|(old_byte & (chk_last_reg ? last_mask : 8'hFF)));
        end
        else
        begin
            any_next = any_reg;
        end
    end

    assign sweep_last = (cnt_reg == CW'(STORE_BYTES - 1));
    assign none_done  = !issue && !chk_valid_reg;
    assign sts        = {req_kind, sweep_last, none_done};

    assign ram_we    = cmd.sweep_wr || (cmd.rmw_wr && wr_ok);
    assign ram_waddr = cmd.sweep_wr ? cnt_reg[AW-1:0] : item_addr;
    assign ram_wdata = cmd.sweep_wr ? 8'hFF : new_byte;
    assign ram_raddr = cmd.cap ? req_addr : cnt_reg[AW-1:0];

    rsb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (old_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mlen_reg      <= MASK_LEN_RESET;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mlen_reg <= cfg_wr_data;
            end
            cnt_reg       <= cnt_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_last_reg <= chk_last_next;
        any_reg      <= any_next;
        if (cmd.cap)
        begin
            item_reg <= req;
        end
        if (cmd.save_res)
        begin
            res_reg <= fin_res;
        end
        if (cmd.load_out)
        begin
            rsp_reg <= cmd.use_saved ? res_reg : fin_res;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/row_selection_bitmap_core.sv =====
// Bit, byte and merge commands: item and byte latched in IDLE, result registered in MODIFY.
// Fill ones: all (MAX_BITS+7)/8 bytes set to 0xFF, one byte per cycle through the single write port.
// None query: the ceil(used bits / 8) bytes in use are read, one byte per cycle.
// A result waits in the output register while items go on, else in a save register stalling them.
// Reset: mask_length = 4096, then a clearing pass sets every one of the (MAX_BITS+7)/8
// bytes to 0xFF while req_stall stays high.
`default_nettype none

module row_selection_bitmap_core #(
    parameter int MAX_BITS = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire rsb_pkg::req_t                   req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output rsb_pkg::rsp_t                        rsp,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rsb_pkg::MASK_LEN_W-1:0]  cfg_wr_data
);

    import rsb_pkg::*;

    ctrl_t ctrl;
    sts_t  sts;

    rsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (ctrl)
    );

    rsb_datapath #(
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .cmd         (ctrl),
        .sts         (sts),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rsb_checker.sv =====
`default_nettype none

module rsb_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire rsb_pkg::rsp_t rsp
);

    // Held result keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Clearing pass blocks items straight after reset
    a_reset_stall: assert property (@(posedge clk)
        !rst_n |=> req_stall)
        else $error("item port open during clearing pass");

    // Every accepted item takes the block out of IDLE, so req_stall rises behind it
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("item taken on consecutive cycles");

    // A new result only follows a busy cycle
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result with no work behind it");

    // Flags from different commands never combine
    a_flag_mix: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.is_none && (rsp.read_bit || rsp.index_error)))
        else $error("none flag mixed with bit command flags");

endmodule

bind row_selection_bitmap_core rsb_checker u_rsb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
